// ===== src/d2i_pkg.sv =====
// Package: format codes and shared types for the binary64 to integer converter.
package d2i_pkg;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned TypeWidth  = 3;
  localparam int unsigned ExpBias    = 1023;
  localparam int unsigned MantBits   = 52;

  typedef enum logic [TypeWidth-1:0] {
    FmtS8  = 3'd0,
    FmtU8  = 3'd1,
    FmtS16 = 3'd2,
    FmtU16 = 3'd3,
    FmtS32 = 3'd4,
    FmtU32 = 3'd5,
    FmtS64 = 3'd6,
    FmtU64 = 3'd7
  } fmt_e;

  typedef struct packed {
    logic [ValueWidth-1:0] result_bits;
    logic                  clamped;
  } d2i_res_t;

endpackage

// ===== src/double_to_int_saturating_convert.sv =====
// Top level: input register, conversion logic, output register with skid-free flow.
// A request passes through the input register, then the result register.
// Throughput: one request per cycle while the result is not stalled, set by the single-pass conversion logic.
// A stalled result holds; the input register advances whenever the result stage can move.
// Reset (rst_ni low, asynchronous) clears both valid flags; payload is not reset.
module double_to_int_saturating_convert (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [d2i_pkg::TypeWidth-1:0]  req_type_i,
  input  logic [d2i_pkg::ValueWidth-1:0] value_bits_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [d2i_pkg::ValueWidth-1:0] result_bits_o,
  output logic                           clamped_o
);
  import d2i_pkg::*;

  logic                  in_vld_q, out_vld_q;
  logic [TypeWidth-1:0]  type_q;
  logic [ValueWidth-1:0] val_q;
  d2i_res_t              res_d, res_q;
  logic                  out_adv, in_adv;

  // Advance when the next stage is free or draining
  assign out_adv    = !out_vld_q || !out_stall_i;
  assign in_adv     = !in_vld_q || out_adv;
  assign in_stall_o = !in_adv;

  d2i_core u_core (
    .req_type_i  (type_q),
    .value_bits_i(val_q),
    .res_o       (res_d)
  );

  // Control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_adv) in_vld_q <= in_valid_i;
      if (out_adv) out_vld_q <= in_vld_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_adv && in_valid_i) begin
      type_q <= req_type_i;
      val_q  <= value_bits_i;
    end
    if (out_adv && in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign result_bits_o = res_q.result_bits;
  assign clamped_o     = res_q.clamped;

endmodule

// ===== src/d2i_core.sv =====
// Combinational conversion of one binary64 pattern to a saturated integer.
module d2i_core (
  input  logic [d2i_pkg::TypeWidth-1:0]  req_type_i,
  input  logic [d2i_pkg::ValueWidth-1:0] value_bits_i,
  output d2i_pkg::d2i_res_t              res_o
);
  import d2i_pkg::*;

  logic        neg;
  logic [10:0] expo;
  logic [51:0] mant;
  logic        is_nan, huge, is_signed;
  logic [10:0] e;
  logic [52:0] sig;
  logic [63:0] mag;
  logic [63:0] lim, maxv;
  logic [5:0]  sh;

  // Decode fields, build the truncated magnitude and select the target limits
  always_comb begin
    neg       = value_bits_i[63];
    expo      = value_bits_i[62:52];
    mant      = value_bits_i[51:0];
    is_nan    = (expo == 11'h7ff) && (mant != '0);
    sig       = {1'b1, mant};
    e         = expo - 11'(ExpBias);
    huge      = 1'b0;
    mag       = '0;
    sh        = '0;
    if (expo == 11'h7ff) begin
      huge = 1'b1;
    end else if (expo >= 11'(ExpBias)) begin
      if (e >= 11'd64) begin
        huge = 1'b1;
      end else if (e >= 11'(MantBits)) begin
        sh  = 6'(e - 11'(MantBits));
        mag = {11'd0, sig} << sh;
      end else begin
        sh  = 6'(11'(MantBits) - e);
        mag = {11'd0, sig} >> sh;
      end
    end
    is_signed = ~req_type_i[0];
    case (req_type_i[2:1])
      2'd0:    lim = 64'h80;
      2'd1:    lim = 64'h8000;
      2'd2:    lim = 64'h8000_0000;
      default: lim = 64'h8000_0000_0000_0000;
    endcase
    maxv = (lim << 1) - 64'd1;
  end

  // Saturate against the target range
  always_comb begin
    res_o.result_bits = mag;
    res_o.clamped     = 1'b0;
    if (is_nan) begin
      res_o.result_bits = '0;
      res_o.clamped     = 1'b1;
    end else if (is_signed) begin
      if (!neg) begin
        if (huge || mag > lim - 64'd1) begin
          res_o.result_bits = lim - 64'd1;
          res_o.clamped     = 1'b1;
        end
      end else if (huge || mag > lim) begin
        res_o.result_bits = 64'd0 - lim;
        res_o.clamped     = 1'b1;
      end else begin
        res_o.result_bits = 64'd0 - mag;
      end
    end else if (neg) begin
      res_o.result_bits = '0;
      res_o.clamped     = huge || (mag != '0);
    end else if (huge || mag > maxv) begin
      res_o.result_bits = maxv;
      res_o.clamped     = 1'b1;
    end
  end

endmodule
